// ===== sv/rhp_pkg.sv =====
`timescale 1ns / 1ps

package rhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_SOURCE  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TRUNCATED = 2'd1,
    STATUS_EXTENSION = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SOURCES = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  version;
    logic        padding;
    logic        marker;
    logic [6:0]  payload_type;
    logic [3:0]  source_count;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] source_id;
    logic [7:0]  payload_value;
    status_t     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  localparam int RHP_FIFO_DEPTH = 4;
  localparam logic [3:0] HDR_LAST_POS = 4'd11;
  localparam logic [3:0] WORD_BYTES = 4'd4;

endpackage

// ===== sv/rhp_out_fifo.sv =====
`timescale 1ns / 1ps

module rhp_out_fifo #(
  parameter int DEPTH = rhp_pkg::RHP_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  rhp_pkg::push_t   push,
  output logic             room,
  output logic             valid,
  input  logic             pop,
  output rhp_pkg::result_t head
);
  import rhp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   wr_ptr2;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr2 = bump(wr_ptr);
  assign room    = count <= CW'(DEPTH - 2);
  assign valid   = count != '0;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr2] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      unique case (push.count)
        2'd0:    wr_ptr <= wr_ptr;
        2'd1:    wr_ptr <= wr_ptr2;
        default: wr_ptr <= bump(wr_ptr2);
      endcase
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

endmodule

// ===== sv/rtp_header_parser.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  item   (one packet byte, last mark)
// output    out        out_valid/out_stall  result (header, source, byte, end)
//
// One byte is taken per cycle while in_stall is low; a byte passes an input
// register and is parsed from there, once the queue has room, into a small
// output queue, which holds up to four results. A byte that gives two results
// pushes both at once. Reset is synchronous, empties the queue and returns the
// parser to the start of a packet. Input stall rises while the input register
// holds a byte and the queue has fewer than two free places.

module rtp_header_parser #(
  parameter int FIFO_DEPTH = rhp_pkg::RHP_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rhp_pkg::item_t   item,
  output logic             out_valid,
  input  logic             out_stall,
  output rhp_pkg::result_t result
);
  import rhp_pkg::*;

  item_t       in_q;
  logic        in_full;
  logic        in_full_next;
  logic        advance;
  logic        room;

  phase_t      phase;
  phase_t      phase_next;
  phase_t      phase_after;
  logic [3:0]  byte_position;
  logic [3:0]  byte_position_next;
  logic [3:0]  pos_inc;
  logic [15:0] first_header_word;
  logic [15:0] first_header_word_next;
  logic [15:0] held_sequence;
  logic [15:0] held_sequence_next;
  logic [31:0] held_timestamp;
  logic [31:0] held_timestamp_next;
  logic [31:0] word_shift;
  logic [31:0] word_shift_next;
  logic [31:0] ws_shift;
  logic [3:0]  sources_left;
  logic [3:0]  sources_left_next;
  logic [3:0]  cc;
  logic        drop_rest;
  logic        drop_rest_next;
  logic        word_done;
  result_t     end_res;
  push_t       push;

  assign advance  = in_full && room;
  assign in_stall = in_full && !room;

  always_comb begin
    in_full_next = in_full;
    if (in_valid && !in_stall) begin
      in_full_next = 1'b1;
    end else if (advance) begin
      in_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= item;
    end
  end

  assign ws_shift = {word_shift[23:0], in_q.data_byte};
  assign pos_inc  = byte_position + 4'd1;
  assign cc       = first_header_word[11:8];

  always_comb begin
    phase_next             = phase;
    phase_after            = phase;
    byte_position_next     = byte_position;
    first_header_word_next = first_header_word;
    held_sequence_next     = held_sequence;
    held_timestamp_next    = held_timestamp;
    word_shift_next        = word_shift;
    sources_left_next      = sources_left;
    drop_rest_next         = drop_rest;
    word_done              = 1'b0;
    push                   = '0;
    end_res                = '0;
    end_res.kind           = KIND_END;
    end_res.last           = 1'b1;

    if (advance) begin
      if (drop_rest) begin
        if (in_q.last_byte) begin
          drop_rest_next     = 1'b0;
          phase_next         = PH_HEADER;
          byte_position_next = '0;
        end
      end else begin
        unique case (phase)
          PH_SOURCES: begin
            word_shift_next    = ws_shift;
            byte_position_next = pos_inc;
            word_done          = pos_inc >= WORD_BYTES;
            if (word_done) begin
              push.count           = 2'd1;
              push.first.kind      = KIND_SOURCE;
              push.first.source_id = ws_shift;
              byte_position_next   = '0;
              sources_left_next    = sources_left - 4'd1;
              if (sources_left_next == '0) begin
                phase_after = PH_PAYLOAD;
              end
            end
            phase_next = phase_after;
            if (in_q.last_byte) begin
              end_res.status = (phase_after == PH_SOURCES) ? STATUS_TRUNCATED : STATUS_OK;
              if (word_done) begin
                push.count  = 2'd2;
                push.second = end_res;
              end else begin
                push.count = 2'd1;
                push.first = end_res;
              end
              phase_next         = PH_HEADER;
              byte_position_next = '0;
            end
          end
          PH_PAYLOAD: begin
            push.count               = 2'd1;
            push.first.kind          = KIND_PAYLOAD;
            push.first.payload_value = in_q.data_byte;
            if (in_q.last_byte) begin
              push.count         = 2'd2;
              push.second        = end_res;
              phase_next         = PH_HEADER;
              byte_position_next = '0;
            end
          end
          default: begin
            if (byte_position < 4'd2) begin
              first_header_word_next = {first_header_word[7:0], in_q.data_byte};
            end else if (byte_position < 4'd4) begin
              held_sequence_next = {held_sequence[7:0], in_q.data_byte};
            end else if (byte_position < 4'd8) begin
              held_timestamp_next = {held_timestamp[23:0], in_q.data_byte};
            end else begin
              word_shift_next = ws_shift;
            end

            if (byte_position < HDR_LAST_POS) begin
              byte_position_next = pos_inc;
              if (in_q.last_byte) begin
                end_res.status     = STATUS_TRUNCATED;
                push.count         = 2'd1;
                push.first         = end_res;
                phase_next         = PH_HEADER;
                byte_position_next = '0;
              end
            end else if (first_header_word[12]) begin
              end_res.status     = STATUS_EXTENSION;
              push.count         = 2'd1;
              push.first         = end_res;
              phase_next         = PH_HEADER;
              byte_position_next = '0;
              drop_rest_next     = !in_q.last_byte;
            end else begin
              push.count              = 2'd1;
              push.first.kind         = KIND_HEADER;
              push.first.version      = first_header_word[15:14];
              push.first.padding      = first_header_word[13];
              push.first.marker       = first_header_word[7];
              push.first.payload_type = first_header_word[6:0];
              push.first.source_count = cc;
              push.first.sequence_res = held_sequence;
              push.first.timestamp    = held_timestamp;
              push.first.source_id    = ws_shift;
              sources_left_next       = cc;
              byte_position_next      = '0;
              word_shift_next         = '0;
              phase_next              = (cc != '0) ? PH_SOURCES : PH_PAYLOAD;
              if (in_q.last_byte) begin
                end_res.status = (cc != '0) ? STATUS_TRUNCATED : STATUS_OK;
                push.count     = 2'd2;
                push.second    = end_res;
                phase_next     = PH_HEADER;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full           <= 1'b0;
      phase             <= PH_HEADER;
      byte_position     <= '0;
      first_header_word <= '0;
      held_sequence     <= '0;
      held_timestamp    <= '0;
      word_shift        <= '0;
      sources_left      <= '0;
      drop_rest         <= 1'b0;
    end else begin
      in_full           <= in_full_next;
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      first_header_word <= first_header_word_next;
      held_sequence     <= held_sequence_next;
      held_timestamp    <= held_timestamp_next;
      word_shift        <= word_shift_next;
      sources_left      <= sources_left_next;
      drop_rest         <= drop_rest_next;
    end
  end

  rhp_out_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .valid(out_valid),
    .pop  (out_valid && !out_stall),
    .head (result)
  );

endmodule

// ===== sv/rhp_checker.sv =====
`timescale 1ns / 1ps

module rhp_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input rhp_pkg::result_t result
);
  import rhp_pkg::*;

  // A stalled result transfer keeps its result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled result changed or vanished");

  // Every end-of-packet result closes the packet.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result.kind == KIND_END |-> result.last)
    else $error("end result without last");

  // Only an end-of-packet result closes the packet.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result.last |-> result.kind == KIND_END)
    else $error("last on a result that is not an end result");

  // Reset empties the output queue.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (.*);

// ===== tb/rtp_header_parser_test.sv =====
`timescale 1ns / 1ps

module rtp_header_parser_test;
  import rhp_pkg::*;

  localparam int BYTE_TARGET = 1050;
  localparam int CYCLE_LIMIT = 200000;

  class rtp_parse_tracker;
    phase_t      phase;
    logic [3:0]  pos;
    logic [15:0] hdr_word;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] shift;
    logic [3:0]  csrc_left;
    logic        dropping;
    result_t     owed_results[$];
    int          mismatches;

    function new();
      phase = PH_HEADER;
      pos = '0;
      hdr_word = '0;
      seq = '0;
      stamp = '0;
      shift = '0;
      csrc_left = '0;
      dropping = 1'b0;
      mismatches = 0;
    endfunction

    function result_t blank(kind_t k);
      result_t r;
      r = '0;
      r.kind = k;
      return r;
    endfunction

    function void push_end(status_t st);
      result_t r;
      r = blank(KIND_END);
      r.status = st;
      r.last = 1'b1;
      owed_results.push_back(r);
    endfunction

    function void start_packet();
      phase = PH_HEADER;
      pos = '0;
    endfunction

    function void take_byte(item_t it);
      result_t    r;
      logic [7:0] b;
      logic       lb;
      logic [3:0] cc;
      b = it.data_byte;
      lb = it.last_byte;
      if (dropping) begin
        if (lb) begin
          dropping = 1'b0;
          start_packet();
        end
        return;
      end
      case (phase)
        PH_SOURCES: begin
          shift = {shift[23:0], b};
          pos = pos + 4'd1;
          if (pos >= WORD_BYTES) begin
            r = blank(KIND_SOURCE);
            r.source_id = shift;
            owed_results.push_back(r);
            pos = '0;
            csrc_left = csrc_left - 4'd1;
            if (csrc_left == 4'd0) phase = PH_PAYLOAD;
          end
          if (lb) begin
            push_end(phase == PH_SOURCES ? STATUS_TRUNCATED : STATUS_OK);
            start_packet();
          end
        end
        PH_PAYLOAD: begin
          r = blank(KIND_PAYLOAD);
          r.payload_value = b;
          owed_results.push_back(r);
          if (lb) begin
            push_end(STATUS_OK);
            start_packet();
          end
        end
        default: begin
          if (pos < 4'd2) hdr_word = {hdr_word[7:0], b};
          else if (pos < 4'd4) seq = {seq[7:0], b};
          else if (pos < 4'd8) stamp = {stamp[23:0], b};
          else shift = {shift[23:0], b};
          if (pos < HDR_LAST_POS) begin
            pos = pos + 4'd1;
            if (lb) begin
              push_end(STATUS_TRUNCATED);
              start_packet();
            end
          end else if (hdr_word[12]) begin
            push_end(STATUS_EXTENSION);
            start_packet();
            if (!lb) dropping = 1'b1;
          end else begin
            cc = hdr_word[11:8];
            r = blank(KIND_HEADER);
            r.version = hdr_word[15:14];
            r.padding = hdr_word[13];
            r.marker = hdr_word[7];
            r.payload_type = hdr_word[6:0];
            r.source_count = cc;
            r.sequence_res = seq;
            r.timestamp = stamp;
            r.source_id = shift;
            owed_results.push_back(r);
            csrc_left = cc;
            pos = '0;
            shift = '0;
            phase = (cc != 4'd0) ? PH_SOURCES : PH_PAYLOAD;
            if (lb) begin
              push_end(cc != 4'd0 ? STATUS_TRUNCATED : STATUS_OK);
              start_packet();
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result expected none got %p", $time, got);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("version", want.version, got.version);
      compare_field("padding", want.padding, got.padding);
      compare_field("marker", want.marker, got.marker);
      compare_field("payload_type", want.payload_type, got.payload_type);
      compare_field("source_count", want.source_count, got.source_count);
      compare_field("sequence_res", want.sequence_res, got.sequence_res);
      compare_field("timestamp", want.timestamp, got.timestamp);
      compare_field("source_id", want.source_id, got.source_id);
      compare_field("payload_value", want.payload_value, got.payload_value);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  item_t   item = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t result;

  rtp_parse_tracker board;
  logic idling = 1'b1;
  int   bytes_sent = 0;
  int   cycles = 0;

  rtp_header_parser u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .item(item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] value, input logic final_mark);
    int gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    item <= '{data_byte: value, last_byte: final_mark};
    do @(posedge clk); while (in_stall);
    board.take_byte(item);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_result(result);
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] pkt[$];
    int choice;
    int cc;
    int keep;
    logic paused;
    board = new();
    paused = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A one-byte packet, an all-ones header that asks for an extension and
    // is followed by bytes to drop, and a header that owes one source word.
    pkt = {8'h00};
    send_packet(pkt);
    pkt = {};
    repeat (14) pkt.push_back(8'hFF);
    send_packet(pkt);
    pkt = {8'h81};
    repeat (11) pkt.push_back(8'h00);
    send_packet(pkt);

    while (bytes_sent < BYTE_TARGET) begin
      pkt = {};
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0, 1: cc = $urandom_range(0, 15);
          2: cc = 15;
          default: cc = $urandom_range(0, 3);
        endcase
        pkt.push_back({2'($urandom), 1'($urandom), (choice < 18) ? 1'b1 : 1'b0, 4'(cc)});
        repeat (11) pkt.push_back(8'($urandom));
        if (choice < 18) begin
          repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
        end else begin
          repeat (cc * 4) pkt.push_back(8'($urandom));
          repeat ($urandom_range(0, 10)) pkt.push_back(8'($urandom));
          if (choice < 30) begin
            keep = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > keep) void'(pkt.pop_back());
          end
        end
      end
      send_packet(pkt);
      if (!paused && bytes_sent > BYTE_TARGET / 2) begin
        in_valid <= 1'b0;
        while (board.owed_results.size() != 0) @(posedge clk);
        @(negedge clk);
        paused = 1'b1;
      end
      if (bytes_sent > BYTE_TARGET - 150) idling = 1'b0;
    end
    in_valid <= 1'b0;

    while (board.owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
